// File: sv/tun_pkg.sv
// shared types and constants for the triangle unit normal pipeline
package tun_pkg;

    // coordinate and result widths
    localparam int unsigned CoordW = 32;
    localparam int unsigned EdgeW  = 32;   // edge magnitude, |b - a| < 2^32
    localparam int unsigned ProdW  = 64;   // edge magnitude product
    localparam int unsigned CrossW = 65;   // cross component magnitude
    localparam int unsigned LenW   = 7;    // bit length of a cross magnitude, 0..65
    localparam int unsigned MantW  = 31;   // normalised magnitude, top value in [2^30, 2^31)
    localparam int unsigned SumW   = 64;   // sum of squared magnitudes
    localparam int unsigned RootW  = 32;   // integer square root of the sum
    localparam int unsigned QuotW  = 31;   // quotient magnitude, at most 2^30
    localparam int unsigned FracW  = 30;   // fraction bits of Q2.30

    // pipeline depth from transfer in to result strobe
    localparam int unsigned CrossStages = 3;
    localparam int unsigned ScaleStages = 4;
    localparam int unsigned SqrtStages  = RootW;
    localparam int unsigned DivStages   = QuotW + 2;
    localparam int unsigned Latency     = CrossStages + ScaleStages + SqrtStages + DivStages;

    // signed magnitude forms
    typedef struct packed {
        logic              neg;
        logic [EdgeW-1:0]  mag;
    } edge_t;

    typedef struct packed {
        logic              neg;
        logic [ProdW-1:0]  mag;
    } prod_t;

    typedef struct packed {
        logic              neg;
        logic [CrossW-1:0] mag;
    } cross_t;

    // cross product stage to scaling stage
    typedef struct packed {
        logic              valid;
        cross_t [2:0]      n;
    } cross_bus_t;

    // scaling stage to square root
    typedef struct packed {
        logic                  valid;
        logic                  deg;
        logic [2:0]            neg;
        logic [2:0][MantW-1:0] m;
        logic [SumW-1:0]       sum;
    } scale_bus_t;

    // square root to divider
    typedef struct packed {
        logic                  valid;
        logic                  deg;
        logic [2:0]            neg;
        logic [2:0][MantW-1:0] m;
        logic [RootW-1:0]      root;
    } root_bus_t;

endpackage

// File: sv/tun_cross.sv
// edge vectors and exact cross product, three register stages
module tun_cross (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [2:0][tun_pkg::CoordW-1:0]     a,
    input  logic [2:0][tun_pkg::CoordW-1:0]     b,
    input  logic [2:0][tun_pkg::CoordW-1:0]     c,
    output tun_pkg::cross_bus_t                 out
);
    import tun_pkg::*;

    logic         v1_reg, v2_reg, v3_reg;
    edge_t  [2:0] u_reg, u_next, w_reg, w_next;
    prod_t  [2:0] p_reg, p_next, q_reg, q_next;
    cross_t [2:0] n_reg, n_next;

    // edge differences as sign and magnitude
    always_comb
    begin
        logic signed [CoordW:0] du, dw;
        for (int i = 0; i < 3; i++)
        begin
            du = $signed({b[i][CoordW-1], b[i]}) - $signed({a[i][CoordW-1], a[i]});
            dw = $signed({c[i][CoordW-1], c[i]}) - $signed({a[i][CoordW-1], a[i]});
            u_next[i].neg = du[CoordW];
            u_next[i].mag = du[CoordW] ? EdgeW'(-du) : EdgeW'(du);
            w_next[i].neg = dw[CoordW];
            w_next[i].mag = dw[CoordW] ? EdgeW'(-dw) : EdgeW'(dw);
        end
    end

    // the six products, x = 0, y = 1, z = 2
    always_comb
    begin
        p_next[0].mag = u_reg[1].mag * w_reg[2].mag;
        p_next[0].neg = u_reg[1].neg ^ w_reg[2].neg;
        q_next[0].mag = u_reg[2].mag * w_reg[1].mag;
        q_next[0].neg = u_reg[2].neg ^ w_reg[1].neg;
        p_next[1].mag = u_reg[2].mag * w_reg[0].mag;
        p_next[1].neg = u_reg[2].neg ^ w_reg[0].neg;
        q_next[1].mag = u_reg[0].mag * w_reg[2].mag;
        q_next[1].neg = u_reg[0].neg ^ w_reg[2].neg;
        p_next[2].mag = u_reg[0].mag * w_reg[1].mag;
        p_next[2].neg = u_reg[0].neg ^ w_reg[1].neg;
        q_next[2].mag = u_reg[1].mag * w_reg[0].mag;
        q_next[2].neg = u_reg[1].neg ^ w_reg[0].neg;
    end

    // p - q in sign and magnitude
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (p_reg[i].neg != q_reg[i].neg)
            begin
                n_next[i].neg = p_reg[i].neg;
                n_next[i].mag = {1'b0, p_reg[i].mag} + {1'b0, q_reg[i].mag};
            end
            else if (p_reg[i].mag >= q_reg[i].mag)
            begin
                n_next[i].neg = p_reg[i].neg;
                n_next[i].mag = {1'b0, p_reg[i].mag - q_reg[i].mag};
            end
            else
            begin
                n_next[i].neg = !q_reg[i].neg;
                n_next[i].mag = {1'b0, q_reg[i].mag - p_reg[i].mag};
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
        w_reg <= w_next;
        p_reg <= p_next;
        q_reg <= q_next;
        n_reg <= n_next;
    end

    assign out.valid = v3_reg;
    assign out.n     = n_reg;

endmodule

// File: sv/tun_scale.sv
// common shift to 31 bits, squares and their sum, four register stages
module tun_scale (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tun_pkg::cross_bus_t  in,
    output tun_pkg::scale_bus_t  out
);
    import tun_pkg::*;

    logic                  v4_reg, v5_reg, v6_reg, v7_reg;
    cross_t [2:0]          n_reg;
    logic [LenW-1:0]       len_reg, len_next;
    logic [2:0]            neg4_reg, neg5_reg, neg6_reg, neg7_reg;
    logic                  deg5_reg, deg6_reg, deg7_reg;
    logic [2:0][MantW-1:0] m5_reg, m5_next, m6_reg, m7_reg;
    logic [2:0][2*MantW-1:0] sq_reg, sq_next;
    logic [SumW-1:0]       sum_reg, sum_next;

    // bit length of the largest magnitude
    always_comb
    begin
        logic [CrossW-1:0] all;
        all      = in.n[0].mag | in.n[1].mag | in.n[2].mag;
        len_next = '0;
        for (int i = 0; i < CrossW; i++)
        begin
            if (all[i])
            begin
                len_next = LenW'(i + 1);
            end
        end
    end

    // shift every magnitude by the same amount
    always_comb
    begin
        logic [CrossW-1:0] sh;
        for (int i = 0; i < 3; i++)
        begin
            if (len_reg > LenW'(MantW))
            begin
                sh = n_reg[i].mag >> (len_reg - LenW'(MantW));
            end
            else
            begin
                sh = n_reg[i].mag << (LenW'(MantW) - len_reg);
            end
            m5_next[i] = sh[MantW-1:0];
        end
    end

    // squares
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = m5_reg[i] * m5_reg[i];
        end
    end

    // sum of squares, below 3 * 2^62
    assign sum_next = SumW'(sq_reg[0]) + SumW'(sq_reg[1]) + SumW'(sq_reg[2]);

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= in.valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        n_reg    <= in.n;
        len_reg  <= len_next;
        neg4_reg <= {in.n[2].neg, in.n[1].neg, in.n[0].neg};
        m5_reg   <= m5_next;
        neg5_reg <= neg4_reg;
        deg5_reg <= (len_reg == '0);
        sq_reg   <= sq_next;
        m6_reg   <= m5_reg;
        neg6_reg <= neg5_reg;
        deg6_reg <= deg5_reg;
        sum_reg  <= sum_next;
        m7_reg   <= m6_reg;
        neg7_reg <= neg6_reg;
        deg7_reg <= deg6_reg;
    end

    assign out.valid = v7_reg;
    assign out.deg   = deg7_reg;
    assign out.neg   = neg7_reg;
    assign out.m     = m7_reg;
    assign out.sum   = sum_reg;

endmodule

// File: sv/tun_sqrt.sv
// integer square root, one result bit per register stage
module tun_sqrt (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tun_pkg::scale_bus_t  in,
    output tun_pkg::root_bus_t   out
);
    import tun_pkg::*;

    localparam int unsigned RemW = RootW + 2;

    typedef struct packed {
        logic                  deg;
        logic [2:0]            neg;
        logic [2:0][MantW-1:0] m;
        logic [SumW-1:0]       x;
        logic [RemW-1:0]       rem;
        logic [RootW-1:0]      root;
    } sq_stage_t;

    logic      [SqrtStages:0] v_reg;
    sq_stage_t [SqrtStages:0] s_reg;

    // stage 0 is the incoming item
    assign v_reg[0]       = in.valid;
    assign s_reg[0].deg   = in.deg;
    assign s_reg[0].neg   = in.neg;
    assign s_reg[0].m     = in.m;
    assign s_reg[0].x     = in.sum;
    assign s_reg[0].rem   = '0;
    assign s_reg[0].root  = '0;

    for (genvar k = 0; k < SqrtStages; k++)
    begin : g_step
        sq_stage_t s_next;

        // bring in two bits, try (root << 2) | 1
        always_comb
        begin
            logic [RemW-1:0] r2, trial;
            r2    = {s_reg[k].rem[RemW-3:0], s_reg[k].x[SumW-1 -: 2]};
            trial = {s_reg[k].root, 2'b01};
            s_next     = s_reg[k];
            s_next.x   = {s_reg[k].x[SumW-3:0], 2'b00};
            if (r2 >= trial)
            begin
                s_next.rem  = r2 - trial;
                s_next.root = {s_reg[k].root[RootW-2:0], 1'b1};
            end
            else
            begin
                s_next.rem  = r2;
                s_next.root = {s_reg[k].root[RootW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            s_reg[k+1] <= s_next;
        end
    end

    assign out.valid = v_reg[SqrtStages];
    assign out.deg   = s_reg[SqrtStages].deg;
    assign out.neg   = s_reg[SqrtStages].neg;
    assign out.m     = s_reg[SqrtStages].m;
    assign out.root  = s_reg[SqrtStages].root;

endmodule

// File: sv/tun_div.sv
// rounded divide of each magnitude by the root, one quotient bit per stage
module tun_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tun_pkg::root_bus_t            in,
    output logic                          out_valid,
    output logic [2:0][tun_pkg::CoordW-1:0] out_normal,
    output logic                          out_deg
);
    import tun_pkg::*;

    localparam int unsigned NumW = MantW + FracW + 1;

    typedef struct packed {
        logic                  deg;
        logic [2:0]            neg;
        logic [RootW-1:0]      d;
        logic [2:0][RootW-1:0] rem;
        logic [2:0][QuotW-1:0] lo;
        logic [2:0][QuotW-1:0] q;
    } dv_stage_t;

    logic      [QuotW:0]   v_reg;
    dv_stage_t [QuotW:0]   s_reg;
    dv_stage_t             s0_next;
    logic                  vo_reg;
    logic [2:0][CoordW-1:0] nrm_reg, nrm_next;
    logic                  dego_reg;

    // numerator m * 2^30 + root / 2, upper part below the root
    always_comb
    begin
        logic [NumW-1:0] num;
        s0_next     = '0;
        s0_next.deg = in.deg;
        s0_next.neg = in.neg;
        s0_next.d   = in.root;
        for (int i = 0; i < 3; i++)
        begin
            num = {in.m[i], {FracW{1'b0}}} + NumW'(in.root >> 1);
            s0_next.rem[i] = RootW'(num[NumW-1:QuotW]);
            s0_next.lo[i]  = num[QuotW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg[0] <= s0_next;
    end

    for (genvar k = 0; k < QuotW; k++)
    begin : g_step
        dv_stage_t s_next;

        // restoring step on all three components
        always_comb
        begin
            logic [RootW:0] t;
            s_next = s_reg[k];
            for (int i = 0; i < 3; i++)
            begin
                t = {s_reg[k].rem[i], s_reg[k].lo[i][QuotW-1]};
                s_next.lo[i] = {s_reg[k].lo[i][QuotW-2:0], 1'b0};
                if (t >= {1'b0, s_reg[k].d})
                begin
                    s_next.rem[i] = RootW'(t - {1'b0, s_reg[k].d});
                    s_next.q[i]   = {s_reg[k].q[i][QuotW-2:0], 1'b1};
                end
                else
                begin
                    s_next.rem[i] = RootW'(t);
                    s_next.q[i]   = {s_reg[k].q[i][QuotW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            s_reg[k+1] <= s_next;
        end
    end

    // apply signs, force zero on a degenerate triangle
    always_comb
    begin
        logic [CoordW-1:0] qx;
        for (int i = 0; i < 3; i++)
        begin
            qx = CoordW'(s_reg[QuotW].q[i]);
            if (s_reg[QuotW].deg)
            begin
                nrm_next[i] = '0;
            end
            else if (s_reg[QuotW].neg[i])
            begin
                nrm_next[i] = -qx;
            end
            else
            begin
                nrm_next[i] = qx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else
        begin
            vo_reg <= v_reg[QuotW];
        end
    end

    always_ff @(posedge clk)
    begin
        nrm_reg  <= nrm_next;
        dego_reg <= s_reg[QuotW].deg;
    end

    assign out_valid  = vo_reg;
    assign out_normal = nrm_reg;
    assign out_deg    = dego_reg;

endmodule

// File: sv/triangle_unit_normal.sv
// top level: unit face normal of a triangle in signed Q2.30
// One triangle is taken on every clock at which start is high; busy is never raised,
// because every unit is fully pipelined and nothing waits on the receiver. Each result
// appears on the normal ports with done high for one cycle, in arrival order, after
// these stages: 3 form the edges and exact cross product, 4 normalise and sum the
// squares, 32 produce the square root one bit per stage and 33 set up the numerators,
// produce the rounded quotients one bit per stage and apply the signs. A zero cross
// product gives a zero normal with degenerate high. Results must be taken as they come.
module triangle_unit_normal (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tun_pkg::CoordW-1:0]  a_x,
    input  logic [tun_pkg::CoordW-1:0]  a_y,
    input  logic [tun_pkg::CoordW-1:0]  a_z,
    input  logic [tun_pkg::CoordW-1:0]  b_x,
    input  logic [tun_pkg::CoordW-1:0]  b_y,
    input  logic [tun_pkg::CoordW-1:0]  b_z,
    input  logic [tun_pkg::CoordW-1:0]  c_x,
    input  logic [tun_pkg::CoordW-1:0]  c_y,
    input  logic [tun_pkg::CoordW-1:0]  c_z,
    output logic                        done,
    output logic [tun_pkg::CoordW-1:0]  normal_x,
    output logic [tun_pkg::CoordW-1:0]  normal_y,
    output logic [tun_pkg::CoordW-1:0]  normal_z,
    output logic                        degenerate
);
    import tun_pkg::*;

    cross_bus_t             cross_bus;
    scale_bus_t             scale_bus;
    root_bus_t              root_bus;
    logic [2:0][CoordW-1:0] nrm;

    // pipeline never stalls
    assign busy = 1'b0;

    tun_cross u_cross (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .a        ({a_z, a_y, a_x}),
        .b        ({b_z, b_y, b_x}),
        .c        ({c_z, c_y, c_x}),
        .out      (cross_bus)
    );

    tun_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (cross_bus),
        .out   (scale_bus)
    );

    tun_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (scale_bus),
        .out   (root_bus)
    );

    tun_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in         (root_bus),
        .out_valid  (done),
        .out_normal (nrm),
        .out_deg    (degenerate)
    );

    assign normal_x = nrm[0];
    assign normal_y = nrm[1];
    assign normal_z = nrm[2];

    // a degenerate result carries a zero normal
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
        else $error("degenerate result with nonzero normal");

    // components never exceed one in Q2.30
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($signed(normal_x) <= 32'sd1073741824) && ($signed(normal_x) >= -32'sd1073741824)
              && ($signed(normal_y) <= 32'sd1073741824) && ($signed(normal_y) >= -32'sd1073741824)
              && ($signed(normal_z) <= 32'sd1073741824) && ($signed(normal_z) >= -32'sd1073741824))
        else $error("normal component out of range");

    // a nondegenerate normal has a nonzero component
    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        done && !degenerate |-> normal_x != '0 || normal_y != '0 || normal_z != '0)
        else $error("nondegenerate result with zero normal");

endmodule
